FILE: hdl/rbp_pkg.sv
// Shared types, constants and fixed-point helpers of the 2D relativistic Boris pusher.
// No dependencies; every other file of the block but rbp_div uses this package.
`default_nettype none
package rbp_pkg;

    localparam int FRAC = 24;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DT         = 2'd0;
    localparam t_cfg_idx CFG_INV_C_SQ   = 2'd1;
    localparam t_cfg_idx CFG_FIELD_TO_B = 2'd2;

    localparam logic [30:0] REG_RESET = 31'd16777216;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] charge;
        logic [30:0]        mass;
        logic signed [31:0] e_x;
        logic signed [31:0] e_y;
        logic signed [31:0] h_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_mom_x;
        logic signed [31:0] new_mom_y;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] v;
        logic               o;
    } t_sat;

    function automatic t_sat sat_q(input logic signed [65:0] x);
        t_sat r;
        if (x > SAT_MAX) begin
            r.v = Q_MAX;
            r.o = 1'b1;
        end else if (x < SAT_MIN) begin
            r.v = Q_MIN;
            r.o = 1'b1;
        end else begin
            r.v = x[31:0];
            r.o = 1'b0;
        end
        return r;
    endfunction

    function automatic t_sat qmul_sat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC;
        return sat_q(66'(s));
    endfunction

    function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] ae;
        logic signed [63:0] be;
        ae = a;
        be = b;
        return ae * be;
    endfunction

    function automatic t_sat div_sat(input logic [31:0] q, input logic ovf, input logic neg);
        logic signed [65:0] m;
        t_sat r;
        m = $signed({34'b0, q});
        if (ovf) begin
            r.v = neg ? Q_MIN : Q_MAX;
            r.o = 1'b1;
        end else begin
            r = sat_q(neg ? -m : m);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/rbp_in_if.sv
// Particle input channel: valid/ready handshake carrying one particle.
// Depends on rbp_pkg for the item type.
`default_nettype none
interface rbp_in_if;
    logic              valid;
    logic              ready;
    rbp_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/rbp_out_if.sv
// Result channel: valid/ready handshake carrying one pushed particle.
// Depends on rbp_pkg for the item type.
`default_nettype none
interface rbp_out_if;
    logic               valid;
    logic               ready;
    rbp_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/rbp_div.sv
// Pipelined restoring divider: signed numerator over positive denominator, 32-bit quotient
// magnitude, one quotient bit per stage, with a sideband that travels alongside. Uses no package.
`default_nettype none
module rbp_div #(
    parameter int NW = 63,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [31:0]          o_quo,
    output logic                 o_ovf,
    output logic                 o_neg,
    output logic [SW-1:0]        o_side
);
    localparam int HW = NW - 32;
    localparam int STEPS = 32;

    logic          r_v0;
    logic [NW-1:0] r_mag;
    logic          r_neg0;
    logic [DW-1:0] r_den0;
    logic [SW-1:0] r_side0;

    logic          r_v    [0:STEPS];
    logic [DW-1:0] r_rem  [0:STEPS];
    logic [31:0]   r_low  [0:STEPS];
    logic [31:0]   r_quo  [0:STEPS];
    logic [DW-1:0] r_den  [0:STEPS];
    logic          r_neg  [0:STEPS];
    logic          r_ovf  [0:STEPS];
    logic [SW-1:0] r_side [0:STEPS];

    logic [DW-1:0] hi_ext;
    assign hi_ext = {{(DW-HW){1'b0}}, r_mag[NW-1:32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v[0] <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_neg0  <= i_num[NW-1];
            r_den0  <= i_den;
            r_side0 <= i_side;
            r_ovf[0]  <= hi_ext >= r_den0;
            r_rem[0]  <= hi_ext;
            r_low[0]  <= r_mag[31:0];
            r_quo[0]  <= '0;
            r_den[0]  <= r_den0;
            r_neg[0]  <= r_neg0;
            r_side[0] <= r_side0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DW:0] trial;
        logic        take;
        assign trial = {r_rem[k], r_low[k][31]};
        assign take  = trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= take ? DW'(trial - {1'b0, r_den[k]}) : DW'(trial);
                r_quo[k+1]  <= {r_quo[k][30:0], take};
                r_low[k+1]  <= {r_low[k][30:0], 1'b0};
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_quo   = r_quo[STEPS];
    assign o_ovf   = r_ovf[STEPS];
    assign o_neg   = r_neg[STEPS];
    assign o_side  = r_side[STEPS];
endmodule
`default_nettype wire

FILE: hdl/rbp_gamma.sv
// Pipelined Lorentz factor sqrt(1 + |u|^2/c^2) in Q8.24: square-and-scale front stages,
// then a digit-by-digit square root, two radicand bits per stage. Depends on rbp_pkg.
`default_nettype none
module rbp_gamma #(
    parameter int SW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_ux,
    input  logic signed [31:0] i_uy,
    input  logic [30:0]        i_inv,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [31:0]        o_gamma,
    output logic               o_ovf,
    output logic [SW-1:0]      o_side
);
    localparam int STEPS = 32;

    logic          r_fv [0:3];
    logic [SW-1:0] r_fs [0:3];
    logic [31:0]   r_mx;
    logic [31:0]   r_my;
    logic [63:0]   r_sqx;
    logic [63:0]   r_sqy;
    logic [39:0]   r_s;
    logic [46:0]   r_ph;
    logic [63:0]   r_pl;

    logic          r_v    [0:STEPS];
    logic [35:0]   r_rem  [0:STEPS];
    logic [31:0]   r_root [0:STEPS];
    logic [63:0]   r_x    [0:STEPS];
    logic          r_big  [0:STEPS];
    logic [SW-1:0] r_side [0:STEPS];

    logic [63:0] sq_sum;
    logic [47:0] g2v;
    assign sq_sum = r_sqx + r_sqy;
    assign g2v = 48'(1 << rbp_pkg::FRAC) + 48'(r_ph) + 48'(r_pl[63:rbp_pkg::FRAC]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv[0] <= 1'b0;
            r_fv[1] <= 1'b0;
            r_fv[2] <= 1'b0;
            r_fv[3] <= 1'b0;
            r_v[0]  <= 1'b0;
        end else if (i_en) begin
            r_fv[0] <= i_valid;
            r_fv[1] <= r_fv[0];
            r_fv[2] <= r_fv[1];
            r_fv[3] <= r_fv[2];
            r_v[0]  <= r_fv[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx  <= i_ux[31] ? 32'(-i_ux) : 32'(i_ux);
            r_my  <= i_uy[31] ? 32'(-i_uy) : 32'(i_uy);
            r_fs[0] <= i_side;
            r_sqx <= 64'(r_mx) * 64'(r_mx);
            r_sqy <= 64'(r_my) * 64'(r_my);
            r_fs[1] <= r_fs[0];
            r_s   <= sq_sum[63:rbp_pkg::FRAC];
            r_fs[2] <= r_fs[1];
            r_ph  <= 47'(r_s) * 47'(i_inv[30:rbp_pkg::FRAC]);
            r_pl  <= 64'(r_s) * 64'(i_inv[rbp_pkg::FRAC-1:0]);
            r_fs[3] <= r_fs[2];
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_x[0]    <= {g2v[39:0], 24'b0};
            r_big[0]  <= |g2v[47:40];
            r_side[0] <= r_fs[3];
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [35:0] t;
        logic [35:0] trial;
        logic        take;
        assign t     = {r_rem[k][33:0], r_x[k][63:62]};
        assign trial = {2'b00, r_root[k], 2'b01};
        assign take  = t >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= take ? t - trial : t;
                r_root[k+1] <= {r_root[k][30:0], take};
                r_x[k+1]    <= {r_x[k][61:0], 2'b00};
                r_big[k+1]  <= r_big[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_gamma = r_big[STEPS] ? 32'hffffffff : r_root[STEPS];
    assign o_ovf   = r_big[STEPS];
    assign o_side  = r_side[STEPS];
endmodule
`default_nettype wire

FILE: hdl/relativistic_boris_push_2d.sv
// Relativistic Boris pusher for 2D particles, signed Q8.24, fully pipelined.
// Depends on rbp_pkg, rbp_in_if, rbp_out_if, rbp_div and rbp_gamma.
//
// Use: one particle (momentum per mass, position, charge, mass, gathered Ex, Ey, Hz) is
// transferred on i_item when valid and ready are high; the pushed momentum, position and
// a saturation flag come out on o_item, one result per particle, in order.
// Registers dt, inv_c_squared and field_to_b_scale are written through i_cfg_*
// (index 0, 1, 2; other indexes are dropped); the user must write them only while the
// pipeline is empty; the block does not enforce this. Stages: fifteen stage registers,
// four 34-stage divider passes (the two velocity dividers run side by side) and two
// 37-stage gamma units in series (one quotient bit or one root bit per stage).
// Throughput: one particle per cycle while the sink takes results.
// Stall: the whole pipeline holds while a result waits on o_item; i_item.ready falls with
// it, so nothing is lost or repeated.
// Reset: all valid bits clear and the three registers return to 1.0.
`default_nettype none
module relativistic_boris_push_2d (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    rbp_in_if.sink      i_item,
    rbp_out_if.source   o_item
);
    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q ux, uy, px, py, ex, ey, b;
        logic flag, mz, nz;
    } t_side_a;
    typedef struct packed {
        t_q umx, umy, ab, kx, ky, px, py;
        logic flag;
    } t_side_g1;
    typedef struct packed {
        t_q umx, umy, kx, ky, px, py;
        logic flag;
    } t_side_b;
    typedef struct packed {
        t_q umx, umy, upx, upy, kx, ky, px, py;
        logic flag;
    } t_side_c;
    typedef struct packed {
        t_q nx, ny, px, py;
        logic flag;
    } t_side_g2;

    logic [30:0] r_dt;
    logic [30:0] r_icc;
    logic [30:0] r_mu;
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= rbp_pkg::REG_RESET;
            r_icc <= rbp_pkg::REG_RESET;
            r_mu  <= rbp_pkg::REG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbp_pkg::CFG_DT:         r_dt  <= i_cfg_data;
                rbp_pkg::CFG_INV_C_SQ:   r_icc <= i_cfg_data;
                rbp_pkg::CFG_FIELD_TO_B: r_mu  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_q dt_q;
    t_q mu_q;
    assign dt_q = $signed({1'b0, r_dt});
    assign mu_q = $signed({1'b0, r_mu});

    // pipeline registers
    logic r_s1_val, r_s2_val, r_s3_val, r_s4_val, r_s5_val;
    logic r_s6_val, r_s7_val, r_s8_val, r_s9_val, r_s10_val;
    logic r_s11_val, r_s12_val, r_s13_val, r_s14_val, r_o_val;

    rbp_pkg::t_in_item  r_s1;
    logic signed [63:0] r_s2_num, r_s2_bp;
    logic [31:0]        r_s2_den;
    logic               r_s2_mz, r_s2_nz;
    t_q                 r_s2_ux, r_s2_uy, r_s2_px, r_s2_py, r_s2_ex, r_s2_ey;
    t_side_a            r_s3;
    t_q                 r_s3_a;
    logic signed [63:0] r_s4_ax, r_s4_ay, r_s4_ab;
    t_q                 r_s4_ux, r_s4_uy, r_s4_px, r_s4_py;
    logic               r_s4_flag;
    t_side_g1           r_s5;
    t_side_b            r_s6;
    t_q                 r_s6_bb;
    logic signed [63:0] r_s7_p1, r_s7_p2, r_s7_p3;
    t_side_b            r_s7;
    t_q                 r_s7_bb;
    t_side_c            r_s8;
    t_q                 r_s8_bb;
    logic [39:0]        r_s8_den;
    t_side_c            r_s9;
    t_q                 r_s9_s;
    logic signed [63:0] r_s10_p1, r_s10_p2;
    t_side_c            r_s10;
    t_q                 r_s11_nx, r_s11_ny, r_s11_kx, r_s11_ky, r_s11_px, r_s11_py;
    logic               r_s11_flag;
    t_side_g2           r_s12;
    t_q                 r_s13_vx, r_s13_vy, r_s13_px, r_s13_py, r_s13_nx, r_s13_ny;
    logic               r_s13_flag;
    logic signed [63:0] r_s14_dx, r_s14_dy;
    t_q                 r_s14_px, r_s14_py, r_s14_nx, r_s14_ny;
    logic               r_s14_flag;
    rbp_pkg::t_out_item r_o;

    assign en = ~r_o_val | o_item.ready;
    assign i_item.ready = en;
    assign o_item.valid = r_o_val;
    assign o_item.data  = r_o;

    // unit outputs
    logic        a_val, a_ovf, a_neg;
    logic [31:0] a_quo;
    logic [$bits(t_side_a)-1:0] a_side_bits;
    t_side_a     a_side;
    logic        g1_val, g1_ovf;
    logic [31:0] g1_g;
    logic [$bits(t_side_g1)-1:0] g1_side_bits;
    t_side_g1    g1_side;
    logic        b_val, b_ovf, b_neg;
    logic [31:0] b_quo;
    logic [$bits(t_side_b)-1:0] b_side_bits;
    t_side_b     b_side;
    logic        c_val, c_ovf, c_neg;
    logic [31:0] c_quo;
    logic [$bits(t_side_c)-1:0] c_side_bits;
    t_side_c     c_side;
    logic        g2_val, g2_ovf;
    logic [31:0] g2_g;
    logic [$bits(t_side_g2)-1:0] g2_side_bits;
    t_side_g2    g2_side;
    logic        x_val, x_ovf, x_neg, y_val, y_ovf, y_neg, y_gbig;
    logic [31:0] x_quo, y_quo;
    logic [$bits(t_side_g2)-1:0] x_side_bits;
    t_side_g2    x_side;

    assign a_side  = t_side_a'(a_side_bits);
    assign g1_side = t_side_g1'(g1_side_bits);
    assign b_side  = t_side_b'(b_side_bits);
    assign c_side  = t_side_c'(c_side_bits);
    assign g2_side = t_side_g2'(g2_side_bits);
    assign x_side  = t_side_g2'(x_side_bits);

    // combinational stage logic
    rbp_pkg::t_sat b_sat, a_div, kx_s, ky_s, ab_s, umx_s, umy_s, bb_s;
    rbp_pkg::t_sat m1_s, m2_s, up1_s, up2_s, s_s, n1_s, n2_s, n3_s, n4_s, nx_s, ny_s;
    rbp_pkg::t_sat vx_s, vy_s, dx_s, dy_s, px_s, py_s;
    t_q   n_a;
    logic n_a_flag;
    t_side_a  n_side_a;
    t_side_g1 n_side_g1;
    t_side_b  n_side_b;
    t_side_c  n_side_c;
    t_side_g2 n_side_g2;
    t_side_a  n_s3;
    t_side_b  n_s6;
    t_side_c  n_s9;

    assign b_sat = rbp_pkg::qmul_sat(r_s2_bp);
    assign n_side_a = '{ux: r_s2_ux, uy: r_s2_uy, px: r_s2_px, py: r_s2_py, ex: r_s2_ex,
                        ey: r_s2_ey, b: b_sat.v, flag: b_sat.o, mz: r_s2_mz, nz: r_s2_nz};

    assign a_div = rbp_pkg::div_sat(a_quo, a_ovf, a_neg);
    always_comb begin
        if (a_side.mz) begin
            n_a      = a_side.nz ? '0 : (a_neg ? rbp_pkg::Q_MIN : rbp_pkg::Q_MAX);
            n_a_flag = ~a_side.nz;
        end else begin
            n_a      = a_div.v;
            n_a_flag = a_div.o;
        end
    end

    always_comb begin
        n_s3      = a_side;
        n_s3.flag = a_side.flag | n_a_flag;
        n_s6      = b_side;
        n_s6.flag = b_side.flag | bb_s.o;
        n_s9      = c_side;
        n_s9.flag = c_side.flag | s_s.o;
    end

    assign kx_s  = rbp_pkg::qmul_sat(r_s4_ax);
    assign ky_s  = rbp_pkg::qmul_sat(r_s4_ay);
    assign ab_s  = rbp_pkg::qmul_sat(r_s4_ab);
    assign umx_s = rbp_pkg::sat_q(66'(r_s4_ux) + 66'(kx_s.v));
    assign umy_s = rbp_pkg::sat_q(66'(r_s4_uy) + 66'(ky_s.v));
    assign n_side_g1 = '{umx: umx_s.v, umy: umy_s.v, ab: ab_s.v, kx: kx_s.v, ky: ky_s.v,
                         px: r_s4_px, py: r_s4_py,
                         flag: r_s4_flag | kx_s.o | ky_s.o | ab_s.o | umx_s.o | umy_s.o};

    assign n_side_b = '{umx: g1_side.umx, umy: g1_side.umy, kx: g1_side.kx, ky: g1_side.ky,
                        px: g1_side.px, py: g1_side.py, flag: g1_side.flag | g1_ovf};

    assign bb_s  = rbp_pkg::div_sat(b_quo, b_ovf, b_neg);
    assign m1_s  = rbp_pkg::qmul_sat(r_s7_p1);
    assign m2_s  = rbp_pkg::qmul_sat(r_s7_p2);
    assign up1_s = rbp_pkg::sat_q(66'(r_s7.umx) + 66'(m1_s.v));
    assign up2_s = rbp_pkg::sat_q(66'(r_s7.umy) - 66'(m2_s.v));
    assign n_side_c = '{umx: r_s7.umx, umy: r_s7.umy, upx: up1_s.v, upy: up2_s.v,
                        kx: r_s7.kx, ky: r_s7.ky, px: r_s7.px, py: r_s7.py,
                        flag: r_s7.flag | m1_s.o | m2_s.o | up1_s.o | up2_s.o};

    assign s_s  = rbp_pkg::div_sat(c_quo, c_ovf, c_neg);
    assign n1_s = rbp_pkg::qmul_sat(r_s10_p1);
    assign n2_s = rbp_pkg::qmul_sat(r_s10_p2);
    assign n3_s = rbp_pkg::sat_q(66'(r_s10.umx) + 66'(n1_s.v));
    assign n4_s = rbp_pkg::sat_q(66'(r_s10.umy) - 66'(n2_s.v));
    assign nx_s = rbp_pkg::sat_q(66'(r_s11_nx) + 66'(r_s11_kx));
    assign ny_s = rbp_pkg::sat_q(66'(r_s11_ny) + 66'(r_s11_ky));
    assign n_side_g2 = '{nx: nx_s.v, ny: ny_s.v, px: r_s11_px, py: r_s11_py,
                         flag: r_s11_flag | nx_s.o | ny_s.o};

    assign vx_s = rbp_pkg::div_sat(x_quo, x_ovf, x_neg);
    assign vy_s = rbp_pkg::div_sat(y_quo, y_ovf, y_neg);
    assign dx_s = rbp_pkg::qmul_sat(r_s14_dx);
    assign dy_s = rbp_pkg::qmul_sat(r_s14_dy);
    assign px_s = rbp_pkg::sat_q(66'(r_s14_px) + 66'(dx_s.v));
    assign py_s = rbp_pkg::sat_q(66'(r_s14_py) + 66'(dy_s.v));

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_val  <= 1'b0;
            r_s2_val  <= 1'b0;
            r_s3_val  <= 1'b0;
            r_s4_val  <= 1'b0;
            r_s5_val  <= 1'b0;
            r_s6_val  <= 1'b0;
            r_s7_val  <= 1'b0;
            r_s8_val  <= 1'b0;
            r_s9_val  <= 1'b0;
            r_s10_val <= 1'b0;
            r_s11_val <= 1'b0;
            r_s12_val <= 1'b0;
            r_s13_val <= 1'b0;
            r_s14_val <= 1'b0;
            r_o_val   <= 1'b0;
        end else if (en) begin
            r_s1_val  <= i_item.valid;
            r_s2_val  <= r_s1_val;
            r_s3_val  <= a_val;
            r_s4_val  <= r_s3_val;
            r_s5_val  <= r_s4_val;
            r_s6_val  <= b_val;
            r_s7_val  <= r_s6_val;
            r_s8_val  <= r_s7_val;
            r_s9_val  <= c_val;
            r_s10_val <= r_s9_val;
            r_s11_val <= r_s10_val;
            r_s12_val <= r_s11_val;
            r_s13_val <= x_val & y_val;
            r_s14_val <= r_s13_val;
            r_o_val   <= r_s14_val;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= i_item.data;

            r_s2_num <= rbp_pkg::smul(dt_q, r_s1.charge);
            r_s2_bp  <= rbp_pkg::smul(mu_q, r_s1.h_z);
            r_s2_den <= {r_s1.mass, 1'b0};
            r_s2_mz  <= r_s1.mass == '0;
            r_s2_nz  <= (r_dt == '0) || (r_s1.charge == '0);
            r_s2_ux  <= r_s1.mom_x;
            r_s2_uy  <= r_s1.mom_y;
            r_s2_px  <= r_s1.pos_x;
            r_s2_py  <= r_s1.pos_y;
            r_s2_ex  <= r_s1.e_x;
            r_s2_ey  <= r_s1.e_y;

            r_s3   <= n_s3;
            r_s3_a <= n_a;

            r_s4_ax   <= rbp_pkg::smul(r_s3_a, r_s3.ex);
            r_s4_ay   <= rbp_pkg::smul(r_s3_a, r_s3.ey);
            r_s4_ab   <= rbp_pkg::smul(r_s3_a, r_s3.b);
            r_s4_ux   <= r_s3.ux;
            r_s4_uy   <= r_s3.uy;
            r_s4_px   <= r_s3.px;
            r_s4_py   <= r_s3.py;
            r_s4_flag <= r_s3.flag;

            r_s5 <= n_side_g1;

            r_s6    <= n_s6;
            r_s6_bb <= bb_s.v;

            r_s7_p1 <= rbp_pkg::smul(r_s6_bb, r_s6.umy);
            r_s7_p2 <= rbp_pkg::smul(r_s6_bb, r_s6.umx);
            r_s7_p3 <= rbp_pkg::smul(r_s6_bb, r_s6_bb);
            r_s7    <= r_s6;
            r_s7_bb <= r_s6_bb;

            r_s8     <= n_side_c;
            r_s8_bb  <= r_s7_bb;
            r_s8_den <= 40'(1 << rbp_pkg::FRAC) + {1'b0, r_s7_p3[62:rbp_pkg::FRAC]};

            r_s9   <= n_s9;
            r_s9_s <= s_s.v;

            r_s10_p1 <= rbp_pkg::smul(r_s9_s, r_s9.upy);
            r_s10_p2 <= rbp_pkg::smul(r_s9_s, r_s9.upx);
            r_s10    <= r_s9;

            r_s11_nx   <= n3_s.v;
            r_s11_ny   <= n4_s.v;
            r_s11_kx   <= r_s10.kx;
            r_s11_ky   <= r_s10.ky;
            r_s11_px   <= r_s10.px;
            r_s11_py   <= r_s10.py;
            r_s11_flag <= r_s10.flag | n1_s.o | n2_s.o | n3_s.o | n4_s.o;

            r_s12 <= n_side_g2;

            r_s13_vx   <= vx_s.v;
            r_s13_vy   <= vy_s.v;
            r_s13_px   <= x_side.px;
            r_s13_py   <= x_side.py;
            r_s13_nx   <= x_side.nx;
            r_s13_ny   <= x_side.ny;
            r_s13_flag <= x_side.flag | y_gbig | vx_s.o | vy_s.o;

            r_s14_dx   <= rbp_pkg::smul(dt_q, r_s13_vx);
            r_s14_dy   <= rbp_pkg::smul(dt_q, r_s13_vy);
            r_s14_px   <= r_s13_px;
            r_s14_py   <= r_s13_py;
            r_s14_nx   <= r_s13_nx;
            r_s14_ny   <= r_s13_ny;
            r_s14_flag <= r_s13_flag;

            r_o.new_mom_x <= r_s14_nx;
            r_o.new_mom_y <= r_s14_ny;
            r_o.new_pos_x <= px_s.v;
            r_o.new_pos_y <= py_s.v;
            r_o.overflow  <= r_s14_flag | dx_s.o | dy_s.o | px_s.o | py_s.o;
        end
    end

    rbp_div #(.NW(63), .DW(32), .SW($bits(t_side_a))) u_div_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_s2_val), .i_num(r_s2_num[62:0]), .i_den(r_s2_den), .i_side(n_side_a),
        .o_valid(a_val), .o_quo(a_quo), .o_ovf(a_ovf), .o_neg(a_neg), .o_side(a_side_bits)
    );

    rbp_gamma #(.SW($bits(t_side_g1))) u_gamma_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_s5_val), .i_ux(r_s5.umx), .i_uy(r_s5.umy), .i_inv(r_icc), .i_side(r_s5),
        .o_valid(g1_val), .o_gamma(g1_g), .o_ovf(g1_ovf), .o_side(g1_side_bits)
    );

    rbp_div #(.NW(56), .DW(32), .SW($bits(t_side_b))) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(g1_val), .i_num($signed({g1_side.ab, 24'b0})), .i_den(g1_g),
        .i_side(n_side_b),
        .o_valid(b_val), .o_quo(b_quo), .o_ovf(b_ovf), .o_neg(b_neg), .o_side(b_side_bits)
    );

    rbp_div #(.NW(57), .DW(40), .SW($bits(t_side_c))) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_s8_val), .i_num($signed({r_s8_bb, 25'b0})), .i_den(r_s8_den),
        .i_side(r_s8),
        .o_valid(c_val), .o_quo(c_quo), .o_ovf(c_ovf), .o_neg(c_neg), .o_side(c_side_bits)
    );

    rbp_gamma #(.SW($bits(t_side_g2))) u_gamma_end (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_s12_val), .i_ux(r_s12.nx), .i_uy(r_s12.ny), .i_inv(r_icc), .i_side(r_s12),
        .o_valid(g2_val), .o_gamma(g2_g), .o_ovf(g2_ovf), .o_side(g2_side_bits)
    );

    rbp_div #(.NW(56), .DW(32), .SW($bits(t_side_g2))) u_div_vx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(g2_val), .i_num($signed({g2_side.nx, 24'b0})), .i_den(g2_g),
        .i_side(g2_side_bits),
        .o_valid(x_val), .o_quo(x_quo), .o_ovf(x_ovf), .o_neg(x_neg), .o_side(x_side_bits)
    );

    rbp_div #(.NW(56), .DW(32), .SW(1)) u_div_vy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(g2_val), .i_num($signed({g2_side.ny, 24'b0})), .i_den(g2_g),
        .i_side(g2_ovf),
        .o_valid(y_val), .o_quo(y_quo), .o_ovf(y_ovf), .o_neg(y_neg), .o_side(y_gbig)
    );
endmodule
`default_nettype wire

FILE: hdl/rbp_check.sv
// Port-level checks of the Boris pusher's handshakes, bound to the top level.
// Depends on rbp_pkg for the result type.
`default_nettype none
module rbp_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input rbp_pkg::t_out_item i_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track the output stall");

    a_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("pipeline held with no result waiting");
endmodule

bind relativistic_boris_push_2d rbp_check u_check (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_item.ready),
    .i_out_valid(o_item.valid),
    .i_out_ready(o_item.ready),
    .i_out_data(o_item.data)
);
`default_nettype wire
